/* design/float32_reciprocal_sqrt_defines.svh */
// Assertion macros for the reciprocal square root pipeline.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef FLOAT32_RECIPROCAL_SQRT_DEFINES_SVH
`define FLOAT32_RECIPROCAL_SQRT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRSQ_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("frsq check failed");

// Consequent must hold in the cycle after the antecedent.
`define FRSQ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("frsq check failed");

`endif

/* design/frsq_pkg.sv */
// Shared types, constants and helpers for the reciprocal square root pipeline.
// No dependencies.
`default_nettype none

package frsq_pkg;

    localparam int SqrtSteps = 26;
    localparam int DivSteps  = 28;

    localparam logic [31:0] QuietBit = 32'h0040_0000;
    localparam logic [31:0] CanonNan = 32'h7FC0_0000;
    localparam logic [31:0] PosInf   = 32'h7F80_0000;
    localparam logic [31:0] NegInf   = 32'hFF80_0000;
    localparam logic [31:0] PosZero  = 32'h0000_0000;

    // Side data that travels with every request.
    typedef struct packed {
        logic               special;
        logic [31:0]        spec_val;
        logic signed [9:0]  ex;
    } tag_t;

    // Leading zero count of a 24-bit word; a zero input gives zero.
    function automatic logic [4:0] clz24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* design/frsq_sqrt_step.sv */
// One registered step of the bit-pair integer square root recurrence.
// Depends on frsq_pkg.
`default_nettype none

module frsq_sqrt_step (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  wire frsq_pkg::tag_t in_tag,
    input  wire [51:0]          in_rad,
    input  wire [27:0]          in_rem,
    input  wire [25:0]          in_root,
    output logic                out_valid,
    output frsq_pkg::tag_t      out_tag,
    output logic [51:0]         out_rad,
    output logic [27:0]         out_rem,
    output logic [25:0]         out_root
);

    logic [29:0] rem_sh;
    logic [29:0] trial;
    logic [29:0] diff;
    logic        ge;

    assign rem_sh = {in_rem, in_rad[51:50]};
    assign trial  = {2'b00, in_root, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_tag  <= in_tag;
            out_rad  <= {in_rad[49:0], 2'b00};
            out_rem  <= diff[27:0];
            out_root <= {in_root[24:0], ge};
        end
    end

endmodule

`default_nettype wire

/* design/frsq_div_step.sv */
// One registered step of the restoring division of 2^50 by the root significand.
// Depends on frsq_pkg.
`default_nettype none

module frsq_div_step (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  wire frsq_pkg::tag_t in_tag,
    input  wire [23:0]          in_ms,
    input  wire [24:0]          in_r,
    input  wire [27:0]          in_q,
    output logic                out_valid,
    output frsq_pkg::tag_t      out_tag,
    output logic [23:0]         out_ms,
    output logic [24:0]         out_r,
    output logic [27:0]         out_q
);

    logic [25:0] r_sh;
    logic        ge;
    logic [25:0] diff;

    assign r_sh = {in_r, 1'b0};
    assign ge   = r_sh >= {2'b00, in_ms};
    assign diff = ge ? (r_sh - {2'b00, in_ms}) : r_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_tag <= in_tag;
            out_ms  <= in_ms;
            out_r   <= diff[24:0];
            out_q   <= {in_q[26:0], ge};
        end
    end

endmodule

`default_nettype wire

/* design/float32_reciprocal_sqrt.sv */
// Streaming binary32 reciprocal square root: y = 1/sqrt(x), formed as a
// nearest-even square root followed by a nearest-even reciprocal, with IEEE
// special cases and full subnormal support. One request is accepted per cycle
// while the output buffer is not full; each passes decode, 26 square root steps,
// root rounding, 28 division steps, final rounding and the output register.
// A two-entry output buffer lets the pipeline keep accepting while a result
// waits; the whole pipeline holds only when both output entries are full.
// Depends on frsq_pkg, frsq_sqrt_step, frsq_div_step and the defines header.
`default_nettype none
`include "float32_reciprocal_sqrt_defines.svh"

module float32_reciprocal_sqrt (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [31:0]  s_tdata,    // [31:0] x_bits
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata     // [31:0] y_bits
);

    localparam int NS = frsq_pkg::SqrtSteps;
    localparam int ND = frsq_pkg::DivSteps;

    logic en;

    // ---------------- decode ----------------
    logic [7:0]         x_exp;
    logic [22:0]        x_frac;
    logic [4:0]         lz;
    logic [23:0]        m_norm;
    logic signed [9:0]  e_raw;
    logic signed [9:0]  e_even;
    logic [24:0]        m_even;
    frsq_pkg::tag_t     dec_tag;

    always_comb begin
        x_exp  = s_tdata[30:23];
        x_frac = s_tdata[22:0];
        lz     = frsq_pkg::clz24({1'b0, x_frac});
        if (x_exp == 8'd0) begin
            m_norm = {1'b0, x_frac} << lz;
            e_raw  = -10'sd149 - $signed({5'd0, lz});
        end else begin
            m_norm = {1'b1, x_frac};
            e_raw  = $signed({2'b00, x_exp}) - 10'sd150;
        end
        if (e_raw[0]) begin
            m_even = {m_norm, 1'b0};
            e_even = e_raw - 10'sd1;
        end else begin
            m_even = {1'b0, m_norm};
            e_even = e_raw;
        end
        dec_tag.ex       = (e_even - 10'sd26) >>> 1;
        dec_tag.special  = 1'b1;
        dec_tag.spec_val = frsq_pkg::PosZero;
        if (x_exp == 8'hFF && x_frac != 23'd0) begin
            dec_tag.spec_val = s_tdata | frsq_pkg::QuietBit;
        end else if (s_tdata[30:0] == 31'd0) begin
            dec_tag.spec_val = s_tdata[31] ? frsq_pkg::NegInf : frsq_pkg::PosInf;
        end else if (s_tdata[31]) begin
            dec_tag.spec_val = frsq_pkg::CanonNan;
        end else if (x_exp == 8'hFF) begin
            dec_tag.spec_val = frsq_pkg::PosZero;
        end else begin
            dec_tag.special = 1'b0;
        end
    end

    logic              sq_v    [0:NS];
    frsq_pkg::tag_t    sq_tag  [0:NS];
    logic [51:0]       sq_rad  [0:NS];
    logic [27:0]       sq_rem  [0:NS];
    logic [25:0]       sq_root [0:NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v[0] <= 1'b0;
        end else if (en) begin
            sq_v[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_tag[0]  <= dec_tag;
            sq_rad[0]  <= {1'b0, m_even, 26'd0};
            sq_rem[0]  <= 28'd0;
            sq_root[0] <= 26'd0;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        frsq_sqrt_step u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (sq_v[k]),
            .in_tag   (sq_tag[k]),
            .in_rad   (sq_rad[k]),
            .in_rem   (sq_rem[k]),
            .in_root  (sq_root[k]),
            .out_valid(sq_v[k+1]),
            .out_tag  (sq_tag[k+1]),
            .out_rad  (sq_rad[k+1]),
            .out_rem  (sq_rem[k+1]),
            .out_root (sq_root[k+1])
        );
    end

    // ---------------- round the root ----------------
    logic [25:0]        r;
    logic               r_sticky;
    logic [23:0]        r_mant;
    logic               r_guard;
    logic               r_st;
    logic signed [9:0]  r_eadd;
    logic [24:0]        r_sum;
    logic [23:0]        r_ms;
    frsq_pkg::tag_t     r_tag;

    always_comb begin
        r        = sq_root[NS];
        r_sticky = sq_rem[NS] != 28'd0;
        if (r[25]) begin
            r_mant = r[25:2];
            r_guard = r[1];
            r_st   = r[0] | r_sticky;
            r_eadd = 10'sd2;
        end else begin
            r_mant = r[24:1];
            r_guard = r[0];
            r_st   = r_sticky;
            r_eadd = 10'sd1;
        end
        r_sum = {1'b0, r_mant} + {24'd0, r_guard & (r_st | r_mant[0])};
        if (r_sum[24]) begin
            r_ms   = r_sum[24:1];
            r_eadd = r_eadd + 10'sd1;
        end else begin
            r_ms = r_sum[23:0];
        end
        r_tag    = sq_tag[NS];
        r_tag.ex = sq_tag[NS].ex + r_eadd;
    end

    logic              dv_v   [0:ND];
    frsq_pkg::tag_t    dv_tag [0:ND];
    logic [23:0]       dv_ms  [0:ND];
    logic [24:0]       dv_r   [0:ND];
    logic [27:0]       dv_q   [0:ND];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v[0] <= 1'b0;
        end else if (en) begin
            dv_v[0] <= sq_v[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_tag[0] <= r_tag;
            dv_ms[0]  <= r_ms;
            dv_r[0]   <= 25'd1 << 22;
            dv_q[0]   <= 28'd0;
        end
    end

    for (genvar k = 0; k < ND; k++) begin : g_div
        frsq_div_step u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (dv_v[k]),
            .in_tag   (dv_tag[k]),
            .in_ms    (dv_ms[k]),
            .in_r     (dv_r[k]),
            .in_q     (dv_q[k]),
            .out_valid(dv_v[k+1]),
            .out_tag  (dv_tag[k+1]),
            .out_ms   (dv_ms[k+1]),
            .out_r    (dv_r[k+1]),
            .out_q    (dv_q[k+1])
        );
    end

    // ---------------- round the quotient ----------------
    logic [27:0]        q;
    logic               q_sticky;
    logic [23:0]        q_mant;
    logic               q_guard;
    logic               q_st;
    logic signed [9:0]  q_exp;
    logic [24:0]        q_sum;
    logic [22:0]        q_frac;
    logic [31:0]        y_val;

    always_comb begin
        q        = dv_q[ND];
        q_sticky = dv_r[ND] != 25'd0;
        if (q[27]) begin
            q_mant  = q[27:4];
            q_guard = q[3];
            q_st    = (q[2:0] != 3'd0) | q_sticky;
            q_exp   = 10'sd104 - dv_tag[ND].ex;
        end else begin
            q_mant  = q[26:3];
            q_guard = q[2];
            q_st    = (q[1:0] != 2'd0) | q_sticky;
            q_exp   = 10'sd103 - dv_tag[ND].ex;
        end
        q_sum = {1'b0, q_mant} + {24'd0, q_guard & (q_st | q_mant[0])};
        if (q_sum[24]) begin
            q_frac = q_sum[23:1];
            q_exp  = q_exp + 10'sd1;
        end else begin
            q_frac = q_sum[22:0];
        end
        y_val = dv_tag[ND].special ? dv_tag[ND].spec_val : {1'b0, q_exp[7:0], q_frac};
    end

    logic        fin_v_reg;
    logic [31:0] fin_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_v_reg <= 1'b0;
        end else if (en) begin
            fin_v_reg <= dv_v[ND];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_d_reg <= y_val;
        end
    end

    // ---------------- output register and skid entry ----------------
    logic        out_v_reg, out_v_next;
    logic [31:0] out_d_reg, out_d_next;
    logic        skid_v_reg, skid_v_next;
    logic [31:0] skid_d_reg, skid_d_next;
    logic        take;
    logic        incoming;

    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign take     = out_v_reg && m_tready;
    assign incoming = en && fin_v_reg;

    always_comb begin
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        if (skid_v_reg) begin
            if (take) begin
                out_d_next  = skid_d_reg;
                skid_v_next = 1'b0;
            end
        end else if (incoming) begin
            if (!out_v_reg || take) begin
                out_v_next = 1'b1;
                out_d_next = fin_d_reg;
            end else begin
                skid_v_next = 1'b1;
                skid_d_next = fin_d_reg;
            end
        end else if (take) begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

    `FRSQ_ASSERT_SAME(a_skid_implies_out, skid_v_reg, out_v_reg)
    `FRSQ_ASSERT_NEXT(a_blocked_lands_in_skid, incoming && out_v_reg && !m_tready, skid_v_reg)
    `FRSQ_ASSERT_NEXT(a_skid_drains_on_take, skid_v_reg && m_tready, !skid_v_reg && out_v_reg)

endmodule

`default_nettype wire

/* test/tb.sv */
// Testbench for float32_reciprocal_sqrt: drives binary32 requests through the
// stream ports and checks every result against a bit-exact integer predictor.
// Depends on the RTL top level only.
`default_nettype none

class rsqrt_scoreboard;
    bit [31:0] pending_roots[$];
    int        errors;
    int        checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    // Round (sig + fraction) * 2^e to binary32, nearest even.
    static function bit [31:0] pack_nearest(bit [63:0] sig, int e, bit sticky);
        bit [63:0] mant;
        bit [2:0]  low;
        int        biased;
        while (sig >= 64'd1 << 27) begin
            sticky = sticky | sig[0];
            sig    = sig >> 1;
            e++;
        end
        while (sig < 64'd1 << 26) begin
            sig = sig << 1;
            e--;
        end
        low  = sig[2:0];
        mant = sig >> 3;
        if (low > 3'd4 || (low == 3'd4 && (sticky || mant[0])))
            mant++;
        e += 3;
        if (mant == 64'd1 << 24) begin
            mant = mant >> 1;
            e++;
        end
        biased = e + 150;
        return {1'b0, biased[7:0], mant[22:0]};
    endfunction

    static function bit [31:0] rsqrt_of(bit [31:0] x);
        bit [7:0]  ex;
        bit [22:0] fr;
        bit [63:0] m, op, res, one, q, ms, rem;
        bit [31:0] s;
        int        e, es;
        ex = x[30:23];
        fr = x[22:0];
        if (ex == 8'hFF && fr != 0) return x | 32'h0040_0000;
        if (x[30:0] == 0) return x[31] ? 32'hFF80_0000 : 32'h7F80_0000;
        if (x[31]) return 32'h7FC0_0000;
        if (ex == 8'hFF) return 32'h0;
        if (ex == 0) begin
            m = 64'(fr);
            e = -149;
            while (m < 64'h80_0000) begin
                m = m << 1;
                e--;
            end
        end else begin
            m = {41'd1, fr};
            e = int'(ex) - 150;
        end
        if (e % 2 != 0) begin
            m = m << 1;
            e--;
        end
        // integer square root of m * 2^26
        op  = m << 26;
        res = 0;
        one = 64'd1 << 62;
        while (one > op) one = one >> 2;
        while (one != 0) begin
            if (op >= res + one) begin
                op  = op - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        s   = pack_nearest(res, (e - 26) / 2, op != 0);
        ms  = {41'd1, s[22:0]};
        es  = int'(s[30:23]) - 150;
        q   = (64'd1 << 50) / ms;
        rem = (64'd1 << 50) - q * ms;
        return pack_nearest(q, -50 - es, rem != 0);
    endfunction

    function void note_request(bit [31:0] x);
        pending_roots.push_back(rsqrt_of(x));
    endfunction

    function void check_result(bit [31:0] y);
        bit [31:0] want;
        if (pending_roots.size() == 0) begin
            $display("%0t: unexpected result y_bits=%h", $time, y);
            errors++;
            return;
        end
        want = pending_roots.pop_front();
        checked++;
        if (y !== want) begin
            $display("%0t: y_bits mismatch expected=%h actual=%h", $time, want, y);
            errors++;
        end
    endfunction
endclass

module tb;
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    wire         s_tready;
    logic [31:0] s_tdata;
    wire         m_tvalid;
    logic        m_tready;
    wire  [31:0] m_tdata;

    rsqrt_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    int sent;

    float32_reciprocal_sqrt DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) board.check_result(m_tdata);
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Leaves s_tvalid high after the accepting edge; the next request or
    // drain() decides what it carries next.
    task automatic send_request(input bit [31:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(x);
        sent++;
    endtask

    function automatic bit [31:0] random_value();
        bit [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0: v[30:23] = 8'h00;
            1: v[30:23] = 8'hFF;
            2: v[31] = 1'b1;
            3: v[30:0] = 31'($urandom_range(3));
            default: v[31] = 1'b0;
        endcase
        return v;
    endfunction

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_roots.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    initial begin
        bit [31:0] corner[$];
        int        hold_cycles;
        board          = new();
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        sent           = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        corner = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7F80_0001, 32'hFFFF_FFFF, 32'h7FC0_0000, 32'hFFBF_FFFF,
                   32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF,
                   32'h3F80_0000, 32'h4080_0000, 32'h4000_0000, 32'hBF80_0000,
                   32'h8000_0001, 32'h3F7F_FFFF, 32'h0040_0000, 32'h5555_5555,
                   32'h2AAA_AAAA};
        foreach (corner[i]) send_request(corner[i]);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (int k = 0; k < 320; k++) begin
                if (phase == 2 && k == 20) begin
                    // Hold off the receiver long enough to back up the pipeline.
                    fork
                        begin
                            hold_off = 1'b1;
                            hold_cycles = 0;
                            while (hold_cycles < 150) begin
                                @(posedge aclk);
                                hold_cycles++;
                            end
                            hold_off = 1'b0;
                        end
                    join_none
                end
                if (phase == 1 && k == 160) drain();
                send_request(random_value());
            end
        end

        drain();
        repeat (80) @(posedge aclk);
        $display("Sent %0d requests (corners and random), checked %0d results", sent,
                 board.checked);
        $display("across free-running, sender-idle, receiver-stall and mixed phases.");
        if (board.errors == 0 && board.pending_roots.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

`default_nettype wire
